// ===== hw/rtl/cmps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmps_pkg
// Shared types and constants of the complex magnitude peak search.
// ----------------------------------------------------------------------------
package cmps_pkg;

  localparam int FRAME_GROUPS_W = 11;
  localparam logic [FRAME_GROUPS_W-1:0] FRAME_GROUPS_RST = 11'd256;
  localparam int GROUP_SHIFT = 2;
  localparam int SQRT_STEPS = 16;
  localparam int STEP_W = $clog2(SQRT_STEPS);
  localparam logic [31:0] SQRT_TOP_BIT = 32'h4000_0000;

  typedef struct packed {
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
  } sample_t;

  typedef struct packed {
    logic [15:0] magnitude;
    logic        frame_done;
    logic [11:0] peak_index;
    logic [15:0] peak_magnitude;
  } result_t;

  typedef struct packed {
    logic load;
    logic square;
    logic sum;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cmps_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmps_in_if
// Request channel carrying one complex bin.
// ----------------------------------------------------------------------------
interface cmps_in_if;
  logic              valid;
  logic              ready;
  cmps_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/cmps_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmps_out_if
// Result channel carrying magnitude and frame peak.
// ----------------------------------------------------------------------------
interface cmps_out_if;
  logic              valid;
  logic              ready;
  cmps_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/complex_magnitude_peak_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_magnitude_peak_search
// Per-bin magnitude floor(sqrt(re^2+im^2)) and per-frame peak search.
//
//   channel   dir   width  contents
//   sample    in    32     real_part, imag_part (signed Q1.15)
//   result    out   45     magnitude, frame_done, peak_index, peak_magnitude
//   cfg       in    11     frame_groups (write only)
//
// One request runs through capture, squares, sum, 16 square root steps
// on the shared root-step adder, then peak update and result load.
// A new request is taken once the block is back in idle.
// A full result register that is not taken holds the block before the load.
// Reset is synchronous; frame_groups returns to 256, frame state to zero.
// ----------------------------------------------------------------------------
module complex_magnitude_peak_search #(
  parameter int MAX_BINS = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  cmps_in_if.sink                             sample,
  cmps_out_if.source                          result,
  input  logic                                cfg_we,
  input  logic [cmps_pkg::FRAME_GROUPS_W-1:0] cfg_wdata
);

  cmps_pkg::dp_cmd_t    cmd;
  cmps_pkg::dp_status_t status;

  cmps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (sample.valid),
    .req_ready (sample.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cmps_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample_data (sample.data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_data    (result.data)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/cmps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmps_ctrl
// Sequencer: capture, square, sum, root steps, peak update and result load.
// ----------------------------------------------------------------------------
module cmps_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  cmps_pkg::dp_status_t   status,
  output cmps_pkg::dp_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SQUARE = 5'b00010,
    S_SUM    = 5'b00100,
    S_ROOT   = 5'b01000,
    S_FINISH = 5'b10000
  } ctrl_state_t;

  localparam logic [cmps_pkg::STEP_W-1:0] STEP_LAST =
    cmps_pkg::STEP_W'(cmps_pkg::SQRT_STEPS - 1);

  ctrl_state_t                 state;
  ctrl_state_t                 state_next;
  logic [cmps_pkg::STEP_W-1:0] step;
  logic [cmps_pkg::STEP_W-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        step_next  = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.step  = 1'b1;
        step_next = step + 1'b1;
        if (step == STEP_LAST) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cmps_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmps_dp
// Datapath: squares, bit-pair square root, frame peak tracking, result register.
// ----------------------------------------------------------------------------
module cmps_dp #(
  parameter int MAX_BINS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cmps_pkg::dp_cmd_t                     cmd,
  output cmps_pkg::dp_status_t                  status,
  input  cmps_pkg::sample_t                     sample_data,
  input  logic                                  cfg_we,
  input  logic [cmps_pkg::FRAME_GROUPS_W-1:0]   cfg_wdata,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output cmps_pkg::result_t                     res_data
);

  localparam int CNT_W = $clog2(MAX_BINS);
  localparam int GMAX  = MAX_BINS >> cmps_pkg::GROUP_SHIFT;

  logic [cmps_pkg::FRAME_GROUPS_W-1:0] frame_groups;
  logic [16:0]      abs_re;
  logic [16:0]      abs_im;
  logic [16:0]      ext_re;
  logic [16:0]      ext_im;
  logic [30:0]      sq_re;
  logic [30:0]      sq_im;
  logic [33:0]      prod_re;
  logic [33:0]      prod_im;
  logic [31:0]      rem;
  logic [31:0]      root;
  logic [31:0]      bitv;
  logic [31:0]      trial;
  logic [CNT_W-1:0] bin_cnt;
  logic [15:0]      best_mag;
  logic [CNT_W-1:0] best_idx;
  logic [31:0]      groups_sat;
  logic [31:0]      last_idx;
  logic [15:0]      mag;
  logic             done;
  logic             better;

  assign ext_re  = {sample_data.real_part[15], sample_data.real_part};
  assign ext_im  = {sample_data.imag_part[15], sample_data.imag_part};
  assign prod_re = abs_re * abs_re;
  assign prod_im = abs_im * abs_im;
  assign trial   = root + bitv;
  assign mag     = root[15:0];

  always_comb begin
    groups_sat = 32'(frame_groups);
    if (groups_sat == 32'd0) begin
      groups_sat = 32'd1;
    end else if (groups_sat > 32'(GMAX)) begin
      groups_sat = 32'(GMAX);
    end
    last_idx = (groups_sat << cmps_pkg::GROUP_SHIFT) - 32'd1;
    done     = 32'(bin_cnt) >= last_idx;
    better   = !done && (bin_cnt != '0) && (mag > best_mag);
  end

  assign status.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_groups <= cmps_pkg::FRAME_GROUPS_RST;
    end else if (cfg_we) begin
      frame_groups <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      abs_re <= ext_re[16] ? (~ext_re + 17'd1) : ext_re;
      abs_im <= ext_im[16] ? (~ext_im + 17'd1) : ext_im;
    end
    if (cmd.square) begin
      sq_re <= prod_re[30:0];
      sq_im <= prod_im[30:0];
    end
    if (cmd.sum) begin
      rem  <= 32'(sq_re) + 32'(sq_im);
      root <= '0;
      bitv <= cmps_pkg::SQRT_TOP_BIT;
    end else if (cmd.step) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_cnt   <= '0;
      best_mag  <= '0;
      best_idx  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        res_valid <= 1'b1;
        if (done) begin
          bin_cnt  <= '0;
          best_mag <= '0;
          best_idx <= '0;
        end else begin
          bin_cnt <= bin_cnt + 1'b1;
          if (better) begin
            best_mag <= mag;
            best_idx <= bin_cnt;
          end
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_data.magnitude <= mag;
      res_data.frame_done <= done;
      if (done) begin
        res_data.peak_index     <= 12'(best_idx);
        res_data.peak_magnitude <= best_mag;
      end else begin
        res_data.peak_index     <= '0;
        res_data.peak_magnitude <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cmps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmps_checker
// Port-level checks of the complex magnitude peak search.
// ----------------------------------------------------------------------------
module cmps_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input cmps_pkg::result_t out_data
);

  // drop ready after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after a request");

  a_peak_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.frame_done |->
      out_data.peak_index == 12'd0 && out_data.peak_magnitude == 16'd0)
    else $error("peak fields set off frame end");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.magnitude <= 16'd46340 &&
      out_data.peak_magnitude <= 16'd46340)
    else $error("magnitude out of range");

  a_peak_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.peak_index != 12'd0 |-> out_data.peak_magnitude != 16'd0)
    else $error("peak index without magnitude");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind complex_magnitude_peak_search cmps_checker u_cmps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);
`default_nettype wire
